@@ rtl/tlcs_pkg.sv @@
`default_nettype none
package tlcs_pkg;

  localparam int DefThreadSlots = 16;
  localparam int DefLockCount = 16;
  localparam int DefCondsPerLock = 4;

  localparam logic [3:0] CMD_INIT = 4'd0;
  localparam logic [3:0] CMD_CREATE = 4'd1;
  localparam logic [3:0] CMD_YIELD = 4'd2;
  localparam logic [3:0] CMD_LOCK = 4'd3;
  localparam logic [3:0] CMD_UNLOCK = 4'd4;
  localparam logic [3:0] CMD_WAIT = 4'd5;
  localparam logic [3:0] CMD_SIGNAL = 4'd6;
  localparam logic [3:0] CMD_BCAST = 4'd7;
  localparam logic [3:0] CMD_FINISH = 4'd8;

  typedef struct packed {
    logic [3:0] cmd;
    logic [3:0] lock_id;
    logic [1:0] cond_id;
  } req_t;

  typedef struct packed {
    logic       status;
    logic [3:0] running_thread;
    logic [3:0] new_thread;
    logic       all_done;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CONDPOP,
    ST_CONDLINK,
    ST_DISP,
    ST_DISPLINK,
    ST_DISPCHK,
    ST_RELEASE,
    ST_RELLINK,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic cond_pop;
    logic cond_link;
    logic disp_pop;
    logic disp_link;
    logic disp_chk;
    logic release_pop;
    logic release_link;
    logic respond;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic err_now;
    logic go_release;
    logic go_cond;
    logic go_disp;
    logic cond_more;
    logic ready_ne;
    logic need_link;
    logic blocked;
    logic disp_budget;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/tlcs_ctrl.sv @@
`default_nettype none
module tlcs_ctrl
  import tlcs_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.err_now) state_next = ST_DONE;
        else if (sts.go_release) state_next = ST_RELEASE;
        else if (sts.go_cond) state_next = ST_CONDPOP;
        else if (sts.go_disp) state_next = ST_DISP;
        else state_next = ST_DONE;
      end
      ST_RELEASE: begin
        ctl.release_pop = 1'b1;
        if (sts.need_link) state_next = ST_RELLINK;
        else if (sts.go_disp) state_next = ST_DISP;
        else state_next = ST_DONE;
      end
      ST_RELLINK: begin
        ctl.release_link = 1'b1;
        state_next = sts.go_disp ? ST_DISP : ST_DONE;
      end
      ST_CONDPOP: begin
        if (!sts.cond_more) begin
          state_next = ST_DONE;
        end else begin
          ctl.cond_pop = 1'b1;
          state_next = sts.need_link ? ST_CONDLINK : ST_DONE;
        end
      end
      ST_CONDLINK: begin
        ctl.cond_link = 1'b1;
        state_next = sts.go_cond ? ST_CONDPOP : ST_DONE;
      end
      ST_DISP: begin
        if (!sts.ready_ne || !sts.disp_budget) begin
          ctl.disp_pop = 1'b1;
          state_next = ST_DONE;
        end else begin
          ctl.disp_pop = 1'b1;
          state_next = sts.need_link ? ST_DISPLINK : ST_DISPCHK;
        end
      end
      ST_DISPLINK: begin
        ctl.disp_link = 1'b1;
        state_next = ST_DISPCHK;
      end
      ST_DISPCHK: begin
        ctl.disp_chk = 1'b1;
        state_next = sts.blocked ? ST_DISP : ST_DONE;
      end
      ST_DONE: begin
        ctl.respond = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> state == ST_IDLE) else $error("load outside idle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.respond |=> state == ST_IDLE) else $error("done not followed by idle");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> busy) else $error("start not taken");
`endif

endmodule
`default_nettype wire

@@ rtl/tlcs_dp.sv @@
`default_nettype none
module tlcs_dp
  import tlcs_pkg::*;
#(
  parameter int THREAD_SLOTS = DefThreadSlots,
  parameter int LOCK_COUNT = DefLockCount,
  parameter int CONDS_PER_LOCK = DefCondsPerLock
) (
  input  wire  clk,
  input  wire  rst,
  input  req_t req,
  input  ctl_t ctl,
  output sts_t sts,
  output rsp_t rsp,
  output logic done
);

  localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int LW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int CW = (CONDS_PER_LOCK > 1) ? $clog2(CONDS_PER_LOCK) : 1;
  localparam int QN = LOCK_COUNT * CONDS_PER_LOCK;
  localparam int QW = (QN > 1) ? $clog2(QN) : 1;
  localparam int NW = $clog2(THREAD_SLOTS + 2);

  logic started, exited;
  logic [SW-1:0] cur;
  logic [SW-1:0] rhead, rtail;
  logic          rne;
  logic [SW-1:0] next_link [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] live, retake;
  logic [LW-1:0] retake_lock [THREAD_SLOTS];
  logic [LOCK_COUNT-1:0] own_v, lq_ne;
  logic [SW-1:0] own_s [LOCK_COUNT];
  logic [SW-1:0] lq_h [LOCK_COUNT];
  logic [SW-1:0] lq_t [LOCK_COUNT];
  logic [QN-1:0] cq_ne;
  logic [SW-1:0] cq_h [QN];
  logic [SW-1:0] cq_t [QN];
  // Registered copies of the selected condition queue's head and tail.
  logic [SW-1:0] cqh_r, cqt_r;

  logic [3:0] cmd;
  logic [LW-1:0] lk;
  logic [QW-1:0] qi;
  logic [QW-1:0] qi_in;
  logic bad;
  logic err;
  logic [SW-1:0] fresh;
  logic [SW-1:0] pop_s;
  logic [NW-1:0] dcnt;
  logic [SW-1:0] link_rd;

  logic lk_ok, cd_ok, owns, free_found;
  logic [SW-1:0] free_idx;
  logic [LW-1:0] rl;
  logic [4:0] lk_in;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_found = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign lk_in = {1'b0, req.lock_id};
  assign qi_in = QW'(32'(LW'(lk_in)) * CONDS_PER_LOCK + 32'(CW'(req.cond_id)));
  assign lk_ok = 32'(req.lock_id) < LOCK_COUNT;
  assign cd_ok = 32'(req.cond_id) < CONDS_PER_LOCK;
  assign owns = own_v[lk] && own_s[lk] == cur;
  assign rl = retake_lock[pop_s];

  always_comb begin
    sts = '0;
    sts.err_now = bad ||
      ((cmd == CMD_INIT || cmd == CMD_CREATE) && !free_found) ||
      (cmd == CMD_LOCK && owns) ||
      ((cmd == CMD_UNLOCK || cmd == CMD_WAIT) && !owns);
    sts.go_release = (cmd == CMD_UNLOCK || cmd == CMD_WAIT);
    sts.go_cond = (cmd == CMD_SIGNAL || cmd == CMD_BCAST) &&
                  !(ctl.cond_link && cmd == CMD_SIGNAL);
    sts.go_disp = (cmd == CMD_YIELD || cmd == CMD_WAIT || cmd == CMD_FINISH ||
                   (cmd == CMD_LOCK && own_v[lk]));
    sts.cond_more = cq_ne[qi];
    sts.ready_ne = rne;
    sts.need_link = 1'b0;
    if (ctl.release_pop || (!ctl.cond_pop && !ctl.disp_pop && cmd <= CMD_UNLOCK &&
        cmd != CMD_YIELD && cmd != CMD_LOCK))
      sts.need_link = lq_ne[lk] && lq_h[lk] != lq_t[lk];
    else
      sts.need_link = lq_ne[lk] && lq_h[lk] != lq_t[lk];
    if (cmd == CMD_SIGNAL || cmd == CMD_BCAST)
      sts.need_link = cqh_r != cqt_r;
    if (cmd == CMD_YIELD || cmd == CMD_FINISH || cmd == CMD_LOCK ||
        (cmd == CMD_WAIT && !ctl.release_pop))
      sts.need_link = rhead != rtail;
    if (cmd == CMD_WAIT && ctl.release_pop)
      sts.need_link = lq_ne[lk] && lq_h[lk] != lq_t[lk];
    if (cmd == CMD_WAIT && !ctl.release_pop && !ctl.disp_pop) sts.need_link = rhead != rtail;
    if (cmd == CMD_UNLOCK) sts.need_link = lq_ne[lk] && lq_h[lk] != lq_t[lk];
    sts.blocked = retake[pop_s] && own_v[rl] && own_s[rl] != pop_s;
    sts.disp_budget = 32'(dcnt) <= THREAD_SLOTS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      exited <= 1'b0;
      cur <= '0;
      rne <= 1'b0;
      live <= '0;
      retake <= '0;
      own_v <= '0;
      lq_ne <= '0;
      cq_ne <= '0;
      done <= 1'b0;
    end else begin
      done <= ctl.respond;
      if (ctl.load) begin
        cmd <= req.cmd;
        lk <= LW'(lk_in);
        qi <= qi_in;
        cqh_r <= cq_h[qi_in];
        cqt_r <= cq_t[qi_in];
        bad <= (req.cmd > CMD_FINISH) || exited ||
               (req.cmd == CMD_INIT ? started :
                (!started ||
                 (req.cmd >= CMD_LOCK && req.cmd <= CMD_BCAST && !lk_ok) ||
                 (req.cmd >= CMD_WAIT && req.cmd <= CMD_BCAST && !cd_ok)));
        fresh <= '0;
        dcnt <= '0;
      end
      if (ctl.exec) begin
        err <= sts.err_now;
        if (!sts.err_now) begin
          unique case (cmd)
            CMD_INIT, CMD_CREATE: begin
              live[free_idx] <= 1'b1;
              retake[free_idx] <= 1'b0;
              fresh <= free_idx;
              if (cmd == CMD_INIT) begin
                started <= 1'b1;
                cur <= free_idx;
              end else begin
                if (rne) next_link[rtail] <= free_idx;
                else rhead <= free_idx;
                rtail <= free_idx;
                rne <= 1'b1;
              end
            end
            CMD_YIELD: begin
              if (rne) next_link[rtail] <= cur;
              else rhead <= cur;
              rtail <= cur;
              rne <= 1'b1;
            end
            CMD_LOCK: begin
              if (own_v[lk]) begin
                if (lq_ne[lk]) next_link[lq_t[lk]] <= cur;
                else lq_h[lk] <= cur;
                lq_t[lk] <= cur;
                lq_ne[lk] <= 1'b1;
              end else begin
                own_v[lk] <= 1'b1;
                own_s[lk] <= cur;
              end
            end
            CMD_WAIT: begin
              retake[cur] <= 1'b1;
              retake_lock[cur] <= lk;
              if (cq_ne[qi]) next_link[cqt_r] <= cur;
              else begin
                cq_h[qi] <= cur;
                cqh_r <= cur;
              end
              cq_t[qi] <= cur;
              cqt_r <= cur;
              cq_ne[qi] <= 1'b1;
            end
            CMD_FINISH: live[cur] <= 1'b0;
            default: ;
          endcase
        end
      end
      // Release hands the lock to the first waiter, or frees it when none waits.
      if (ctl.release_pop) begin
        if (lq_ne[lk]) begin
          own_s[lk] <= lq_h[lk];
          if (lq_h[lk] == lq_t[lk]) lq_ne[lk] <= 1'b0;
          else link_rd <= next_link[lq_h[lk]];
          if (rne) next_link[rtail] <= lq_h[lk];
          else rhead <= lq_h[lk];
          rtail <= lq_h[lk];
          rne <= 1'b1;
        end else begin
          own_v[lk] <= 1'b0;
        end
      end
      if (ctl.release_link) lq_h[lk] <= link_rd;
      if (ctl.cond_pop) begin
        if (cqh_r == cqt_r) cq_ne[qi] <= 1'b0;
        else link_rd <= next_link[cqh_r];
        if (rne) next_link[rtail] <= cqh_r;
        else rhead <= cqh_r;
        rtail <= cqh_r;
        rne <= 1'b1;
      end
      if (ctl.cond_link) begin
        cq_h[qi] <= link_rd;
        cqh_r <= link_rd;
      end
      if (ctl.disp_pop) begin
        if (!rne || !sts.disp_budget) begin
          exited <= 1'b1;
        end else begin
          pop_s <= rhead;
          dcnt <= dcnt + NW'(1);
          if (rhead == rtail) rne <= 1'b0;
          else link_rd <= next_link[rhead];
        end
      end
      if (ctl.disp_link) rhead <= link_rd;
      if (ctl.disp_chk) begin
        if (retake[pop_s]) begin
          retake[pop_s] <= 1'b0;
          if (own_v[rl] && own_s[rl] != pop_s) begin
            if (lq_ne[rl]) next_link[lq_t[rl]] <= pop_s;
            else lq_h[rl] <= pop_s;
            lq_t[rl] <= pop_s;
            lq_ne[rl] <= 1'b1;
          end else begin
            own_v[rl] <= 1'b1;
            own_s[rl] <= pop_s;
          end
        end
        if (!sts.blocked) cur <= pop_s;
      end
    end
  end

  always_comb begin
    rsp.status = err;
    rsp.running_thread = (started && !exited) ? 4'(cur) : 4'd0;
    rsp.new_thread = err ? 4'd0 : 4'(fresh);
    rsp.all_done = exited;
  end

`ifndef ASSERT_OFF
  a_retake_live: assert property (@(posedge clk) disable iff (rst)
    ctl.disp_chk |-> !ctl.disp_pop) else $error("dispatch overlap");
  a_exit_sticky: assert property (@(posedge clk) disable iff (rst)
    exited |=> exited) else $error("exit cleared");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double result");
`endif

endmodule
`default_nettype wire

@@ rtl/thread_lock_condvar_scheduler.sv @@
`default_nettype none
// Channel   Signals                 Handshake
// command   start, busy, req        item taken when start && !busy
// result    done, rsp               one-cycle strobe, cannot be stalled
//
// A plain command steps through load, execute and respond; done rises in the
// first cycle that busy is low. Unlock and wait add a release step, plus a
// link step if waiters remain; every dispatch adds a pop, an optional link
// step and a check (only the pop when the library exits), and each ready
// thread parked again on its lock adds another dispatch. Signal adds a pop and
// an optional link; broadcast a pop and link per waiter, no link after the last.
// Reset is synchronous and clears all valid bits at once; no clearing pass.
// The receiver cannot stall, so every result leaves in its strobe cycle.
module thread_lock_condvar_scheduler
  import tlcs_pkg::*;
#(
  parameter int THREAD_SLOTS = DefThreadSlots,
  parameter int LOCK_COUNT = DefLockCount,
  parameter int CONDS_PER_LOCK = DefCondsPerLock
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  ctl_t ctl;
  sts_t sts;

  tlcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  tlcs_dp #(
    .THREAD_SLOTS(THREAD_SLOTS), .LOCK_COUNT(LOCK_COUNT),
    .CONDS_PER_LOCK(CONDS_PER_LOCK)
  ) u_dp (
    .clk(clk), .rst(rst), .req(req), .ctl(ctl), .sts(sts), .rsp(rsp), .done(done)
  );

endmodule
`default_nettype wire
